[hw/rtl/sorted_priority_queue_defines.svh]
// ----------------------------------------------------------------------------
// sorted_priority_queue_defines.svh
// Assertion macros for the sorted priority queue. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on the rising clock edge, disabled while reset is low.
`define SPQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("sorted_priority_queue: assertion failed");

// Check a property on the rising clock edge, also during reset.
`define SPQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("sorted_priority_queue: assertion failed");

`else

`define SPQ_ASSERT(label, clk, rst_n, prop)
`define SPQ_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[hw/rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and widths shared by the sorted priority queue files.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Defaults for the top-level parameters.
    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed field widths of the channels.
    localparam int IN_VALUE_W  = 32;
    localparam int OUT_VALUE_W = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;

    // Width of the extension word between channel and store values.
    localparam int WIDE_W = 64;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_cmd;

endpackage

[hw/rtl/spq_if.sv]
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels for queue commands and their results.
// ----------------------------------------------------------------------------
interface spq_in_if;
    import spq_pkg::*;

    logic                         valid;
    logic                         ready;
    t_op                          op;
    logic signed [IN_VALUE_W-1:0] value_in;

    modport source (output valid, output op, output value_in, input ready);
    modport sink   (input valid, input op, input value_in, output ready);
endinterface

interface spq_out_if;
    import spq_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [OUT_VALUE_W-1:0] value_out;
    t_status                       status;
    logic [COUNT_W-1:0]            count;
    logic                          empty_res;
    logic                          full_res;

    modport source (output valid, output value_out, output status, output count,
                    output empty_res, output full_res, input ready);
    modport sink   (input valid, input value_out, input status, input count,
                    input empty_res, input full_res, output ready);
endinterface

[hw/rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds a value, shifts right on insert, left on
// remove.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  spq_pkg::t_cell_cmd     i_cmd,
    input  logic                   i_occupied,
    input  logic [VALUE_WIDTH-1:0] i_new_value,
    input  logic                   i_left_keep,
    input  logic [VALUE_WIDTH-1:0] i_left_value,
    input  logic [VALUE_WIDTH-1:0] i_right_value,
    output logic                   o_keep,
    output logic [VALUE_WIDTH-1:0] o_value
);
    import spq_pkg::*;

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;

    // Stay in place when holding a value at least as large as the new one.
    assign o_keep  = i_occupied && ($signed(r_value) >= $signed(i_new_value));
    assign o_value = r_value;

    always_comb begin
        priority if (i_cmd.ins && !o_keep) begin
            // First non-keeping slot takes the new value, the rest shift right.
            n_value = i_left_keep ? i_new_value : i_left_value;
        end else if (i_cmd.rem) begin
            n_value = i_right_value;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

[hw/rtl/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue: one transaction per cycle unless stalled; result in the next cycle.
// Every cell compares and shifts in the same cycle; the output register sets the latency.
// Synchronous active-low reset empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue #(
    parameter int CAPACITY    = spq_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    spq_in_if.sink          i_in,
    spq_out_if.source       o_out
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // ------------------------------------------------------------------
    // Control state: fill count and the registered result.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_out_valid;
    logic [OUT_VALUE_W-1:0] r_value_out;
    t_status                r_status;
    logic [COUNT_W-1:0]     r_count_out;
    logic                   r_empty;
    logic                   r_full;

    logic                   w_accept;
    logic                   w_is_full;
    logic                   w_is_empty;
    t_cell_cmd              w_cmd;
    t_status                w_status;
    logic [WIDE_W-1:0]      w_in_wide;
    logic [VALUE_WIDTH-1:0] w_new_value;
    logic [WIDE_W-1:0]      w_head_wide;
    logic                   w_head_order_ok;

    logic [VALUE_WIDTH-1:0] w_value [CAPACITY];
    logic                   w_keep  [CAPACITY];

    // Take a new transaction whenever the result slot is free or drains now.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_is_full  = (r_count == CNT_W'(CAPACITY));
    assign w_is_empty = (r_count == '0);

    // Sign-extend the 32-bit input, then keep VALUE_WIDTH bits.
    assign w_in_wide   = WIDE_W'(i_in.value_in);
    assign w_new_value = w_in_wide[VALUE_WIDTH-1:0];

    // The head cell always holds the largest value; zero-extend for output.
    assign w_head_wide = WIDE_W'(w_value[0]);

    // Refused operations never reach the cells.
    assign w_cmd.ins = w_accept && (i_in.op == OP_INSERT) && !w_is_full;
    assign w_cmd.rem = w_accept && (i_in.op == OP_REMOVE) && !w_is_empty;

    always_comb begin
        n_count  = r_count;
        w_status = ST_OK;
        unique case (i_in.op)
            OP_INSERT: begin
                if (w_is_full) begin
                    w_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (w_is_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_count  = r_count;
                w_status = ST_OK;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Row of cells. Cell 0 is the head; the boundary in front of it acts
    // as a keeping neighbor so an insert at the head takes the new value.
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic                   w_left_keep;
        logic [VALUE_WIDTH-1:0] w_left_value;
        logic [VALUE_WIDTH-1:0] w_right_value;

        if (gi == 0) begin : g_head
            assign w_left_keep  = 1'b1;
            assign w_left_value = w_new_value;
        end else begin : g_body
            assign w_left_keep  = w_keep[gi-1];
            assign w_left_value = w_value[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_tail
            assign w_right_value = w_value[gi];
        end else begin : g_mid
            assign w_right_value = w_value[gi+1];
        end

        spq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_occupied    (CNT_W'(gi) < r_count),
            .i_new_value   (w_new_value),
            .i_left_keep   (w_left_keep),
            .i_left_value  (w_left_value),
            .i_right_value (w_right_value),
            .o_keep        (w_keep[gi]),
            .o_value       (w_value[gi])
        );
    end

    // Hold count and result valid; advance on accept, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, captured with each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value_out <= w_cmd.rem ? w_head_wide[OUT_VALUE_W-1:0] : '0;
            r_status    <= w_status;
            r_count_out <= COUNT_W'(n_count);
            r_empty     <= (n_count == '0);
            r_full      <= (n_count == CNT_W'(CAPACITY));
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.value_out = r_value_out;
    assign o_out.status    = r_status;
    assign o_out.count     = r_count_out;
    assign o_out.empty_res = r_empty;
    assign o_out.full_res  = r_full;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    assign w_head_order_ok = ($signed(w_value[0]) >= $signed(w_value[1]));

    `SPQ_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !r_out_valid)
    `SPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY))
    `SPQ_ASSERT(a_insert_grows, i_clk, i_rst_n, w_cmd.ins |=> r_count == $past(r_count) + CNT_W'(1))
    `SPQ_ASSERT(a_result_count, i_clk, i_rst_n, r_out_valid |-> r_count_out == COUNT_W'(r_count))
    `SPQ_ASSERT(a_head_sorted, i_clk, i_rst_n, (r_count >= CNT_W'(2)) |-> w_head_order_ok)

endmodule

[bench/sorted_priority_queue_tb.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Self-checking bench for the sorted priority queue. A shadow copy of the
// queue predicts each result (removed value, status, count, empty and full)
// from the accepted commands. The result stream is checked in order against
// those predictions while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int MAX_REPORTED = 10;

    // One result as the bench sees it on the output channel.
    typedef struct {
        logic signed [OUT_VALUE_W-1:0] value;
        t_status                       status;
        logic [COUNT_W-1:0]            count;
        logic                          is_empty;
        logic                          is_full;
    } t_result;

    // ------------------------------------------------------------------------
    // Shadow queue and ordered store of expected results
    // ------------------------------------------------------------------------
    class pq_result_checker;
        logic signed [VALUE_WIDTH_DEF-1:0] shadow_queue[$];
        t_result                           expected_results[$];
        int mismatches;
        int checked;
        int inserts;
        int refused;
        int removes;
        int empty_removes;
        int peak;

        // Apply one accepted command to the shadow queue and queue its result.
        function void note_command(t_op op, logic signed [IN_VALUE_W-1:0] value);
            t_result r;
            int      pos;
            r.value  = '0;
            r.status = ST_OK;
            if (op == OP_INSERT) begin
                inserts++;
                if (shadow_queue.size() >= CAP) begin
                    r.status = ST_FULL;
                    refused++;
                end else begin
                    // Equal values stay ahead of the newcomer.
                    pos = 0;
                    while (pos < shadow_queue.size() && shadow_queue[pos] >= value)
                        pos++;
                    shadow_queue.insert(pos, value);
                end
            end else begin
                removes++;
                if (shadow_queue.size() == 0) begin
                    r.status = ST_EMPTY;
                    empty_removes++;
                end else begin
                    r.value = shadow_queue.pop_front();
                end
            end
            if (shadow_queue.size() > peak)
                peak = shadow_queue.size();
            r.count    = COUNT_W'(shadow_queue.size());
            r.is_empty = (shadow_queue.size() == 0);
            r.is_full  = (shadow_queue.size() == CAP);
            expected_results.push_back(r);
        endfunction

        // Compare one result against the oldest prediction.
        function void check_result(t_result got);
            t_result want;
            bit      bad;
            checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("ERROR @%0t: result with no command waiting: value %0d status %0d count %0d",
                             $time, got.value, got.status, got.count);
                return;
            end
            want = expected_results.pop_front();
            bad  = (got.value !== want.value) || (got.status !== want.status) ||
                   (got.count !== want.count) || (got.is_empty !== want.is_empty) ||
                   (got.is_full !== want.is_full);
            if (bad) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("ERROR @%0t: expected value %0d status %0d count %0d empty %b full %b, got value %0d status %0d count %0d empty %b full %b",
                             $time, want.value, want.status, want.count, want.is_empty,
                             want.is_full, got.value, got.status, got.count, got.is_empty,
                             got.is_full);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    spq_in_if  cmd_if ();
    spq_out_if res_if ();

    sorted_priority_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    pq_result_checker checker_h;

    // Percent chance per cycle that the sender holds off or the receiver stalls.
    int send_idle_pct;
    int recv_stall_pct;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Drive ready at the falling edge; stall at the rate of the current phase.
    always @(negedge i_clk) begin
        res_if.ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Sample both channels at the rising edge. A command accepted at this edge
    // cannot produce its result before the next one, so note first, then check.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready)
                checker_h.note_command(cmd_if.op, cmd_if.value_in);
            if (res_if.valid && res_if.ready) begin
                got.value    = res_if.value_out;
                got.status   = res_if.status;
                got.count    = res_if.count;
                got.is_empty = res_if.empty_res;
                got.is_full  = res_if.full_res;
                checker_h.check_result(got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Present one command from a falling edge, hold it until the transaction
    // completes, and return at the following falling edge.
    task automatic send_command(t_op op, logic signed [IN_VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.op       <= op;
        cmd_if.value_in <= value;
        @(posedge i_clk);
        while (!cmd_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mix full-range words, corner values and tight clusters that force ties.
    function automatic logic signed [IN_VALUE_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return int'($urandom_range(8)) - 4;
            2: begin
                case ($urandom_range(3))
                    0: return 32'sh7fff_ffff;
                    1: return 32'sh8000_0000;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return int'($urandom_range(2000)) - 1000;
        endcase
    endfunction

    // Run bursts that lean toward filling, draining or neither, so the queue
    // swings between empty and full over and over.
    task automatic run_random(int n_items);
        int   left;
        int   burst;
        int   ins_pct;
        t_op  op;
        left = n_items;
        while (left > 0) begin
            burst = $urandom_range(40, 8);
            case ($urandom_range(2))
                0: ins_pct = 80;
                1: ins_pct = 20;
                default: ins_pct = 50;
            endcase
            while (burst > 0 && left > 0) begin
                op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
                send_command(op, pick_value());
                burst--;
                left--;
            end
        end
    endtask

    initial begin
        checker_h       = new();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        i_rst_n         = 1'b0;
        cmd_if.valid    = 1'b0;
        cmd_if.op       = OP_INSERT;
        cmd_if.value_in = '0;
        res_if.ready    = 1'b0;

        // Hold reset low, then release it at a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: remove from empty, extremes, ties, then drain past empty.
        send_command(OP_REMOVE, 32'sd0);
        send_command(OP_INSERT, 32'sh7fff_ffff);
        send_command(OP_INSERT, 32'sh8000_0000);
        send_command(OP_INSERT, 32'sd0);
        send_command(OP_INSERT, -32'sd1);
        send_command(OP_INSERT, 32'sd1);
        send_command(OP_INSERT, 32'sd5);
        send_command(OP_INSERT, 32'sd5);
        send_command(OP_INSERT, 32'sh8000_0000);
        send_command(OP_INSERT, 32'sh7fff_ffff);
        repeat (9)
            send_command(OP_REMOVE, $urandom);
        send_command(OP_REMOVE, 32'sh7fff_ffff);
        send_command(OP_REMOVE, -32'sd1);

        // Random phases: free running, slow sender, slow receiver, both.
        run_random(360);
        send_idle_pct = 85;
        run_random(355);
        send_idle_pct  = 0;
        recv_stall_pct = 85;
        run_random(355);
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        run_random(358);
        cmd_if.valid <= 1'b0;

        // Drain: open the receiver, wait for every result, then wait on to catch
        // any stray transaction.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (checker_h.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d commands: %0d inserts (%0d refused while full), %0d removes (%0d on empty)",
                 checker_h.inserts + checker_h.removes, checker_h.inserts, checker_h.refused,
                 checker_h.removes, checker_h.empty_removes);
        $display("Checked %0d results, peak occupancy %0d of %0d, %0d mismatches",
                 checker_h.checked, checker_h.peak, CAP, checker_h.mismatches);
        if (checker_h.mismatches == 0 && checker_h.pending() == 0) begin
            $display("sorted_priority_queue test passed");
        end else begin
            $display("sorted_priority_queue test failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("sorted_priority_queue test failed");
        $finish;
    end

endmodule
